// File: hw/rtl/sv39_page_table_walker_unit_assert.svh
// ----------------------------------------------------------------------------
// Sv39 page table walker assertion macros
// Shared concurrent assertion forms for the walker checks.
// ----------------------------------------------------------------------------
`ifndef SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SV39PTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sv39 walker same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SV39PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sv39 walker next-cycle check failed");

`endif

// File: hw/rtl/sv39ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Widths, field positions, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

    localparam int DEF_STORE_PAGES   = 16;
    localparam int DEF_VA_LIMIT_BITS = 38;

    localparam int ENTRY_W       = 64;
    localparam int PPN_W         = 44;
    localparam int PA_W          = 56;
    localparam int IDX_W         = 13;
    localparam int VA_W          = 39;
    localparam int OFFSET_W      = 12;
    localparam int SLOT_W        = 9;
    localparam int PAGE_SLOTS    = 512;
    localparam int MAX_MEM_WORDS = 8192;
    localparam int MAX_MEM_PAGES = MAX_MEM_WORDS / PAGE_SLOTS;

    localparam int ENTRY_V_BIT = 0;
    localparam int ENTRY_U_BIT = 4;
    localparam int PPN_LSB     = 10;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_SEL_BIT = 3;

    localparam logic REG_ROOT = 1'b0;
    localparam logic REG_BASE = 1'b1;

    localparam logic ACT_WRITE     = 1'b0;
    localparam logic ACT_TRANSLATE = 1'b1;

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;

    typedef struct packed {
        logic       clear;
        logic       wr;
        logic       use_root;
        logic       rd_en;
        logic [1:0] rd_level;
        logic       res_leaf;
        logic       res_fault;
        logic       load_out;
        logic       load_hold;
        logic       from_hold;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic va_ok;
        logic win_ok;
        logic entry_v;
        logic leaf_ok;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/sv39ptw_regs.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker configuration registers
// APB register file holding the root table page and the store base page.
// ----------------------------------------------------------------------------
module sv39ptw_regs
    import sv39ptw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PPN_W-1:0]      o_root_page,
    output logic [PPN_W-1:0]      o_base_page
);

    logic [PPN_W-1:0] r_root;
    logic [PPN_W-1:0] r_base;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_base <= '0;
        end else if (wr_en) begin
            case (paddr[CFG_SEL_BIT])
                REG_ROOT: r_root <= pwdata[PPN_W-1:0];
                REG_BASE: r_base <= pwdata[PPN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[CFG_SEL_BIT])
            REG_ROOT: prdata = {{(CFG_DATA_W-PPN_W){1'b0}}, r_root};
            REG_BASE: prdata = {{(CFG_DATA_W-PPN_W){1'b0}}, r_base};
            default:  prdata = '0;
        endcase
    end

    assign o_root_page = r_root;
    assign o_base_page = r_base;

endmodule

// File: hw/rtl/sv39ptw_ctrl.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker controller
// State machine sequencing the store clear, entry writes and the table walk.
// ----------------------------------------------------------------------------
module sv39ptw_ctrl
    import sv39ptw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_action,
    input  t_status i_st,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_WALK2 = 6'b000100,
        S_WALK1 = 6'b001000,
        S_WALK0 = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   fin;
    logic   fin_fault;
    logic   fin_leaf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_ready   = 1'b0;
        fin       = 1'b0;
        fin_fault = 1'b0;
        fin_leaf  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_st.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr = 1'b1;
                        fin      = 1'b1;
                    end else begin
                        o_cmd.use_root = 1'b1;
                        o_cmd.rd_level = LVL_2;
                        if (i_st.va_ok && i_st.win_ok) begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_WALK2;
                        end else begin
                            fin       = 1'b1;
                            fin_fault = 1'b1;
                        end
                    end
                end
            end
            S_WALK2: begin
                o_cmd.rd_level = LVL_1;
                if (i_st.entry_v && i_st.win_ok) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_WALK1;
                end else begin
                    fin       = 1'b1;
                    fin_fault = 1'b1;
                end
            end
            S_WALK1: begin
                o_cmd.rd_level = LVL_0;
                if (i_st.entry_v && i_st.win_ok) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_WALK0;
                end else begin
                    fin       = 1'b1;
                    fin_fault = 1'b1;
                end
            end
            S_WALK0: begin
                fin = 1'b1;
                if (i_st.leaf_ok) begin
                    fin_leaf = 1'b1;
                end else begin
                    fin_fault = 1'b1;
                end
            end
            S_HOLD: begin
                if (i_st.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.from_hold = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (fin) begin
            o_cmd.res_fault = fin_fault;
            o_cmd.res_leaf  = fin_leaf;
            if (i_st.out_free) begin
                o_cmd.load_out = 1'b1;
                n_state        = S_IDLE;
            end else begin
                o_cmd.load_hold = 1'b1;
                n_state         = S_HOLD;
            end
        end
    end

endmodule

// File: hw/rtl/sv39ptw_dp.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker datapath
// Page store, table address and window check, entry checks and result register.
// ----------------------------------------------------------------------------
module sv39ptw_dp
    import sv39ptw_pkg::*;
#(
    parameter int STORE_PAGES   = DEF_STORE_PAGES,
    parameter int VA_LIMIT_BITS = DEF_VA_LIMIT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_st,
    input  logic [63:0]        i_virtual_address,
    input  logic [IDX_W-1:0]   i_store_index,
    input  logic [ENTRY_W-1:0] i_entry_value,
    input  logic [PPN_W-1:0]   i_root_page,
    input  logic [PPN_W-1:0]   i_base_page,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [PA_W-1:0]    o_physical_address,
    output logic               o_fault
);

    localparam int MEM_PAGES = (STORE_PAGES < MAX_MEM_PAGES) ? STORE_PAGES : MAX_MEM_PAGES;
    localparam int MEM_WORDS = MEM_PAGES * PAGE_SLOTS;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    logic [ENTRY_W-1:0] r_mem [MEM_WORDS];
    logic [ENTRY_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic [VA_W-1:0]    r_va;
    logic               r_o_valid;
    logic [PA_W-1:0]    r_o_pa;
    logic               r_o_fault;
    logic [PA_W-1:0]    r_hold_pa;
    logic               r_hold_fault;

    logic [VA_W-1:0]    va_sel;
    logic [PPN_W-1:0]   table_page;
    logic [PPN_W:0]     diff;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               we;
    logic               idx_ok;
    logic [PA_W-1:0]    res_pa;

    assign va_sel     = i_cmd.use_root ? i_virtual_address[VA_W-1:0] : r_va;
    assign table_page = i_cmd.use_root ? i_root_page : r_rdata[PPN_LSB +: PPN_W];
    assign diff       = {1'b0, table_page} - {1'b0, i_base_page};

    always_comb begin
        case (i_cmd.rd_level)
            LVL_2:   slot = va_sel[OFFSET_W + 2*SLOT_W +: SLOT_W];
            LVL_1:   slot = va_sel[OFFSET_W + SLOT_W +: SLOT_W];
            LVL_0:   slot = va_sel[OFFSET_W +: SLOT_W];
            default: slot = '0;
        endcase
    end

    assign raddr  = ADDR_W'({diff[PPN_W-1:0], slot});
    assign idx_ok = {1'b0, i_store_index} < (IDX_W+1)'(MEM_WORDS);
    assign we     = i_cmd.clear || (i_cmd.wr && idx_ok);
    assign waddr  = i_cmd.clear ? r_clr_cnt : i_store_index[ADDR_W-1:0];
    assign wdata  = i_cmd.clear ? '0 : i_entry_value;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.use_root) begin
            r_va <= i_virtual_address[VA_W-1:0];
        end
    end

    assign res_pa = (i_cmd.res_leaf && !i_cmd.res_fault)
                  ? {r_rdata[PPN_LSB +: PPN_W], r_va[OFFSET_W-1:0]} : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hold) begin
            r_hold_pa    <= res_pa;
            r_hold_fault <= i_cmd.res_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_pa    <= i_cmd.from_hold ? r_hold_pa : res_pa;
            r_o_fault <= i_cmd.from_hold ? r_hold_fault : i_cmd.res_fault;
        end
    end

    assign o_st.clear_last = (r_clr_cnt == ADDR_W'(MEM_WORDS - 1));
    assign o_st.va_ok      = (i_virtual_address[63:VA_LIMIT_BITS] == '0);
    assign o_st.win_ok     = !diff[PPN_W] && (diff[PPN_W-1:0] < PPN_W'(MEM_PAGES));
    assign o_st.entry_v    = r_rdata[ENTRY_V_BIT];
    assign o_st.leaf_ok    = r_rdata[ENTRY_V_BIT] && r_rdata[ENTRY_U_BIT];
    assign o_st.out_free   = !r_o_valid || i_ready;

    assign o_valid            = r_o_valid;
    assign o_physical_address = r_o_pa;
    assign o_fault            = r_o_fault;

endmodule

// File: hw/rtl/sv39_page_table_walker_unit.sv
// Translates virtual addresses through a three-level Sv39 page table kept in a
// local page store, and writes table entries into that store. After reset the
// store is cleared one word per cycle; no item is accepted during that pass,
// while register writes are taken at any time. A translation starts the level-2
// read in the cycle it is accepted, and each of the three dependent reads of
// the single store read port is registered before the next level can be
// addressed. A fault ends the walk early. When the output register is still
// occupied at the end of an item, the result waits in a holding register until
// the output register frees, and it is moved out in the hold state before the
// next item is accepted. The store holds at most 8192 words because the write
// index is 13 bits wide; table pages beyond that lie outside the store window
// and make the walk fault.
`include "sv39_page_table_walker_unit_assert.svh"

// ----------------------------------------------------------------------------
// Sv39 page table walker top level
// Joins the register file, the walk controller and the walk datapath.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit
    import sv39ptw_pkg::*;
#(
    parameter int STORE_PAGES   = DEF_STORE_PAGES,
    parameter int VA_LIMIT_BITS = DEF_VA_LIMIT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [63:0]           i_virtual_address,
    input  logic [IDX_W-1:0]      i_store_index,
    input  logic [ENTRY_W-1:0]    i_entry_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PA_W-1:0]       o_physical_address,
    output logic                  o_fault
);

    t_cmd             cmd;
    t_status          st;
    logic [PPN_W-1:0] root_page;
    logic [PPN_W-1:0] base_page;

    sv39ptw_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_root_page (root_page),
        .o_base_page (base_page)
    );

    sv39ptw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_st     (st),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    sv39ptw_dp #(
        .STORE_PAGES   (STORE_PAGES),
        .VA_LIMIT_BITS (VA_LIMIT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_st               (st),
        .i_virtual_address  (i_virtual_address),
        .i_store_index      (i_store_index),
        .i_entry_value      (i_entry_value),
        .i_root_page        (root_page),
        .i_base_page        (base_page),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_physical_address (o_physical_address),
        .o_fault            (o_fault)
    );

    `SV39PTW_ASSERT_NOW(a_fault_zero_pa, i_clk, i_rst_n, o_valid && o_fault, o_physical_address == '0)
    `SV39PTW_ASSERT_NEXT(a_walk_busy, i_clk, i_rst_n, cmd.rd_en, !o_ready)
    `SV39PTW_ASSERT_NEXT(a_hold_while_full, i_clk, i_rst_n, cmd.load_hold, o_valid)

endmodule

// File: tb/sv/sv39_page_table_walker_unit_test.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker testbench
// Builds page tables in the walker's local store through entry-write items,
// then translates addresses through them. A model of the three-level walk
// predicts each result, which is checked in order against the block's output
// under several register settings and under varied input and output stalls.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptw_pkg::*;

    localparam int          STORE_PAGES = DEF_STORE_PAGES;
    localparam int          VA_BITS     = DEF_VA_LIMIT_BITS;
    localparam int          STORE_WORDS = STORE_PAGES * PAGE_SLOTS;
    localparam int unsigned QUIET_LIMIT = 40000;
    localparam int unsigned PRINT_LIMIT = 40;

    localparam logic [CFG_ADDR_W-1:0] ADDR_ROOT = CFG_ADDR_W'(REG_ROOT) << CFG_SEL_BIT;
    localparam logic [CFG_ADDR_W-1:0] ADDR_BASE = CFG_ADDR_W'(REG_BASE) << CFG_SEL_BIT;

    localparam logic [9:0]       PTE_V   = 10'h001;
    localparam logic [9:0]       PTE_RWX = 10'h00E;
    localparam logic [9:0]       PTE_U   = 10'h010;
    localparam logic [PPN_W-1:0] PPN_MAX = '1;

    typedef struct packed {
        logic [PA_W-1:0] phys;
        logic            flt;
    } t_xlat_result;

    logic                  i_clk;
    logic                  i_rst_n           = 1'b0;
    logic                  psel              = 1'b0;
    logic                  penable           = 1'b0;
    logic                  pwrite            = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr             = '0;
    logic [CFG_DATA_W-1:0] pwdata            = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid           = 1'b0;
    logic                  o_ready;
    logic                  i_action          = ACT_WRITE;
    logic [63:0]           i_virtual_address = '0;
    logic [IDX_W-1:0]      i_store_index     = '0;
    logic [ENTRY_W-1:0]    i_entry_value     = '0;
    logic                  o_valid;
    logic                  i_ready           = 1'b0;
    logic [PA_W-1:0]       o_physical_address;
    logic                  o_fault;

    logic [ENTRY_W-1:0] table_words [STORE_WORDS];
    logic [PPN_W-1:0]   root_ppn = '0;
    logic [PPN_W-1:0]   base_ppn = '0;
    t_xlat_result       due_results [$];
    logic [63:0]        mapped_pages [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_len       = 0;
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned writes_sent    = 0;
    int unsigned lookups_sent   = 0;
    int unsigned faults_due     = 0;
    int unsigned settings_used  = 1;

    sv39_page_table_walker_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_virtual_address  (i_virtual_address),
        .i_store_index      (i_store_index),
        .i_entry_value      (i_entry_value),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_physical_address (o_physical_address),
        .o_fault            (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        foreach (table_words[k]) table_words[k] = '0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PPN_W-1:0] rand44();
        logic [63:0] r;
        r = rand64();
        return r[PPN_W-1:0];
    endfunction

    function automatic logic [63:0] pte(input logic [9:0] rsv, input logic [PPN_W-1:0] ppn,
                                        input logic [9:0] flags);
        return {rsv, ppn, flags};
    endfunction

    function automatic logic [63:0] va_of(input logic [8:0] v2, input logic [8:0] v1,
                                          input logic [8:0] v0, input logic [11:0] off);
        return {25'b0, v2, v1, v0, off};
    endfunction

    function automatic void walk_page_table(input logic [63:0] va, output logic [PA_W-1:0] pa,
                                            output logic flt);
        logic [63:0] page;
        logic [63:0] rel;
        logic [63:0] entry;
        int          lvl;
        pa    = '0;
        flt   = 1'b1;
        entry = '0;
        if ((va >> VA_BITS) != 0) return;
        page = 64'(root_ppn);
        for (lvl = 2; lvl >= 0; lvl--) begin
            if (page < 64'(base_ppn) || page - 64'(base_ppn) >= STORE_PAGES) return;
            rel   = page - 64'(base_ppn);
            entry = table_words[int'(rel) * PAGE_SLOTS
                                + int'(va[OFFSET_W + SLOT_W * lvl +: SLOT_W])];
            if (!entry[ENTRY_V_BIT]) return;
            if (lvl == 0 && !entry[ENTRY_U_BIT]) return;
            page = 64'(entry[PPN_LSB +: PPN_W]);
        end
        pa  = {entry[PPN_LSB +: PPN_W], va[OFFSET_W-1:0]};
        flt = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch %0d at %0t: %s got %h expected %h",
                     mismatches, $realtime, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ROOT) root_ppn = data[PPN_W-1:0];
        else base_ppn = data[PPN_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_tables(input logic [63:0] base, input logic [63:0] root);
        write_reg(ADDR_BASE, base);
        write_reg(ADDR_ROOT, root);
        settings_used++;
    endtask

    task automatic send_item(input logic act, input logic [63:0] va,
                             input logic [IDX_W-1:0] idx, input logic [ENTRY_W-1:0] value);
        t_xlat_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_action          <= act;
        i_virtual_address <= va;
        i_store_index     <= idx;
        i_entry_value     <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = '0;
        if (act == ACT_WRITE) begin
            if (int'(idx) < STORE_WORDS) table_words[idx] = value;
            writes_sent++;
        end else begin
            walk_page_table(va, want.phys, want.flt);
            lookups_sent++;
            if (want.flt) faults_due++;
        end
        due_results.push_back(want);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic map_and_probe();
        logic [8:0]       v2, v1, v0;
        logic [3:0]       root_rel, mid_rel, leaf_rel;
        logic [PPN_W-1:0] mid_ppn, leaf_ppn;
        logic [9:0]       flags;
        logic [63:0]      va;
        root_rel = 4'(root_ppn - base_ppn);
        mid_rel  = 4'($urandom_range(STORE_PAGES - 1));
        leaf_rel = 4'($urandom_range(STORE_PAGES - 1));
        v2 = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(255));
        v1 = 9'($urandom);
        v0 = 9'($urandom);
        mid_ppn  = ($urandom_range(19) == 0) ? rand44() : base_ppn + PPN_W'(mid_rel);
        leaf_ppn = ($urandom_range(19) == 0) ? rand44() : base_ppn + PPN_W'(leaf_rel);

        flags    = 10'($urandom);
        flags[0] = ($urandom_range(19) != 0);
        send_item(ACT_WRITE, rand64(), {root_rel, v2}, pte(10'($urandom), mid_ppn, flags));
        flags    = 10'($urandom);
        flags[0] = ($urandom_range(19) != 0);
        send_item(ACT_WRITE, rand64(), {mid_rel, v1}, pte(10'($urandom), leaf_ppn, flags));
        flags    = 10'($urandom);
        flags[0] = ($urandom_range(14) != 0);
        flags[4] = ($urandom_range(9) != 0);
        send_item(ACT_WRITE, rand64(), {leaf_rel, v0}, pte(10'($urandom), rand44(), flags));

        mapped_pages.push_back(va_of(v2, v1, v0, 12'h000));
        if (mapped_pages.size() > 64) mapped_pages.delete(0);

        repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(2) == 0)
                va = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
            else
                va = va_of(v2, v1, v0, 12'h000);
            va[11:0] = 12'($urandom);
            if ($urandom_range(9) == 0) va = va | (rand64() << VA_BITS);
            send_item(ACT_TRANSLATE, va, IDX_W'($urandom), rand64());
        end

        if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) == 0)
                send_item(ACT_WRITE, rand64(), IDX_W'($urandom), rand64());
            else if ($urandom_range(1) == 0)
                send_item(ACT_TRANSLATE, rand64(), IDX_W'($urandom), rand64());
            else
                send_item(ACT_TRANSLATE, rand64() >> (64 - VA_BITS), IDX_W'($urandom),
                          rand64());
        end
    endtask

    task automatic test_empty_store();
        send_item(ACT_TRANSLATE, 64'h0, '0, '0);
        send_item(ACT_TRANSLATE, '1, '1, '1);
    endtask

    task automatic test_walk_cases();
        send_item(ACT_WRITE, '0, {4'd0, 9'd5}, pte(10'h3FF, 44'd1, PTE_V | PTE_RWX));
        send_item(ACT_WRITE, '0, {4'd1, 9'h1FF}, pte(10'h000, 44'd2, PTE_V));
        send_item(ACT_WRITE, '0, {4'd2, 9'h000}, pte(10'h000, PPN_MAX, PTE_V | PTE_U));
        send_item(ACT_TRANSLATE, va_of(9'd5, 9'h1FF, 9'h000, 12'hFFF), '0, '0);
        send_item(ACT_WRITE, '0, {4'd2, 9'h001}, pte(10'h000, 44'd0, PTE_V | PTE_U));
        send_item(ACT_TRANSLATE, va_of(9'd5, 9'h1FF, 9'h001, 12'hABC), '0, '0);
        send_item(ACT_WRITE, '0, {4'd2, 9'h002}, pte(10'h000, 44'd3, PTE_V | PTE_RWX));
        send_item(ACT_TRANSLATE, va_of(9'd5, 9'h1FF, 9'h002, 12'h000), '0, '0);
        send_item(ACT_WRITE, '0, {4'd1, 9'h1FE}, pte(10'h3FF, 44'd2, PTE_RWX | PTE_U));
        send_item(ACT_TRANSLATE, va_of(9'd5, 9'h1FE, 9'h000, 12'h000), '0, '0);
        send_item(ACT_WRITE, '0, {4'd1, 9'h1FD}, pte(10'h000, 44'(STORE_PAGES), PTE_V));
        send_item(ACT_TRANSLATE, va_of(9'd5, 9'h1FD, 9'h000, 12'h000), '0, '0);
        send_item(ACT_WRITE, '0, {4'd0, 9'd255}, pte(10'h000, 44'd1, PTE_V));
        send_item(ACT_WRITE, '0, {4'd2, 9'h1FF},
                  pte(10'h3FF, 44'h123_4567_89AB, PTE_V | PTE_U));
        send_item(ACT_TRANSLATE, (64'd1 << VA_BITS) - 64'd1, '0, '0);
        send_item(ACT_TRANSLATE, 64'd1 << VA_BITS, '0, '0);
    endtask

    task automatic test_register_extremes();
        logic [PPN_W-1:0] top_base;
        top_base = PPN_MAX - PPN_W'(STORE_PAGES - 1);
        drain();
        set_tables({20'hFFFFF, top_base}, '1);
        send_item(ACT_WRITE, '0, {4'd15, 9'd7}, pte(10'h000, top_base, PTE_V));
        send_item(ACT_WRITE, '0, {4'd0, 9'd8}, pte(10'h000, top_base + 44'd9, PTE_V));
        send_item(ACT_WRITE, '0, {4'd9, 9'd9}, pte(10'h000, PPN_MAX, PTE_V | PTE_U));
        send_item(ACT_TRANSLATE, va_of(9'd7, 9'd8, 9'd9, 12'h123), '0, '0);
        drain();
        write_reg(ADDR_ROOT, 64'(top_base - 44'd1));
        send_item(ACT_TRANSLATE, va_of(9'd7, 9'd8, 9'd9, 12'h123), '0, '0);
        drain();
        set_tables('1, 64'(PPN_MAX));
        send_item(ACT_WRITE, '0, {4'd0, 9'd1}, pte(10'h155, PPN_MAX, PTE_V));
        send_item(ACT_WRITE, '0, {4'd0, 9'd2}, pte(10'h2AA, PPN_MAX, PTE_V));
        send_item(ACT_WRITE, '0, {4'd0, 9'd3}, pte(10'h000, 44'd5, PTE_V | PTE_U));
        send_item(ACT_TRANSLATE, va_of(9'd1, 9'd2, 9'd3, 12'h000), '0, '0);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned budget);
        logic [PPN_W-1:0] base;
        logic [PPN_W-1:0] root;
        int unsigned      stop_at;
        repeat (2) begin
            drain();
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            case ($urandom_range(3))
                0: begin
                    base = '0;
                end
                1: begin
                    base = PPN_MAX - PPN_W'(STORE_PAGES - 1);
                end
                2: begin
                    base = rand44();
                end
                default: begin
                    base = PPN_W'($urandom_range(4095));
                end
            endcase
            if ($urandom_range(9) == 0) root = rand44();
            else root = base + PPN_W'($urandom_range(STORE_PAGES - 1));
            set_tables(64'(base), 64'(root));
            stop_at = items_sent + budget / 2;
            while (items_sent < stop_at) map_and_probe();
        end
    endtask

    task automatic test_output_backpressure();
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 300;
        repeat (8) map_and_probe();
        drain();
    endtask

    initial begin : receiver
        int unsigned held;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                held     = hold_len;
                hold_len = 0;
                repeat (held) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_xlat_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with none outstanding",
                                64'({o_physical_address, o_fault}), '0);
            end else begin
                want = due_results.pop_front();
                if (o_physical_address !== want.phys)
                    report_mismatch("physical_address", 64'(o_physical_address),
                                    64'(want.phys));
                if (o_fault !== want.flt)
                    report_mismatch("fault", 64'(o_fault), 64'(want.flt));
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("** sv39_page_table_walker_unit: FAILED **");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_walk_cases();
        test_register_extremes();
        test_random_traffic(0, 0, 480);
        test_random_traffic(69, 0, 480);
        test_random_traffic(0, 69, 480);
        test_random_traffic(23, 23, 480);
        test_output_backpressure();

        drain();
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", 64'(due_results.size()), '0);
        $display("Sent %0d items: %0d entry writes and %0d translations (%0d expected faults).",
                 items_sent, writes_sent, lookups_sent, faults_due);
        $display("Covered %0d register settings, four stall mixes and one long output hold.",
                 settings_used);
        if (mismatches == 0) begin
            $display("** sv39_page_table_walker_unit: PASSED **");
        end else begin
            $display("** sv39_page_table_walker_unit: FAILED **");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/sv39ptw_pkg.sv
hw/rtl/sv39ptw_regs.sv
hw/rtl/sv39ptw_ctrl.sv
hw/rtl/sv39ptw_dp.sv
hw/rtl/sv39_page_table_walker_unit.sv
tb/sv/sv39_page_table_walker_unit_test.sv
